FILE: hdl/grid_jump_distance_table_macros.svh
// Assertion macros for the grid jump-distance table.
`ifndef GRID_JUMP_DISTANCE_TABLE_MACROS_SVH
`define GRID_JUMP_DISTANCE_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent holds in a cycle: consequent holds in the same cycle.
`define GJDT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent holds in a cycle: consequent holds in the next cycle.
`define GJDT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define GJDT_ASSERT_IMP(lbl, ante, cons, msg)
`define GJDT_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hdl/gjdt_pkg.sv
// Shared constants, types and direction tables of the grid jump-distance table.
`timescale 1ns / 1ps
`default_nettype none

package gjdt_pkg;

  // Grid limits and derived widths
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MIN_DIM    = 3;
  localparam int X_W        = $clog2(MAX_WIDTH);
  localparam int Y_W        = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = X_W + Y_W;
  localparam int MAP_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int DIM_W      = 9;
  localparam int COORD_W    = DIM_W + 1;

  // Distances
  localparam int DIST_W = 8;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Stream widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_PAD_W   = 4;

  // Opcodes carried on tuser
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // Scan directions; bit 2 marks a diagonal
  localparam int NUM_DIR = 8;
  localparam int DIR_W   = 3;
  localparam logic [DIR_W-1:0] DIR_N  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_E  = 3'd1;
  localparam logic [DIR_W-1:0] DIR_S  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_W_ = 3'd3;
  localparam logic [DIR_W-1:0] DIR_NE = 3'd4;
  localparam logic [DIR_W-1:0] DIR_SE = 3'd5;
  localparam logic [DIR_W-1:0] DIR_SW = 3'd6;
  localparam logic [DIR_W-1:0] DIR_NW = 3'd7;

  typedef logic signed [1:0]         off_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [DIST_W-1:0]         dist_t;

  // Outcome of one scan step
  typedef struct packed {
    logic  stop;
    dist_t len;
    logic  jump;
  } step_eval_t;

  localparam off_t OFF_POS  = 2'b01;
  localparam off_t OFF_ZERO = 2'b00;
  localparam off_t OFF_NEG  = 2'b11;

  // Column step of a direction
  function automatic off_t dir_dx(input logic [DIR_W-1:0] dir);
    off_t r;
    case (dir)
      DIR_E, DIR_NE, DIR_SE: r = OFF_POS;
      DIR_W_, DIR_SW, DIR_NW: r = OFF_NEG;
      default: r = OFF_ZERO;
    endcase
    return r;
  endfunction

  // Row step of a direction, north is increasing row
  function automatic off_t dir_dy(input logic [DIR_W-1:0] dir);
    off_t r;
    case (dir)
      DIR_N, DIR_NE, DIR_NW: r = OFF_POS;
      DIR_S, DIR_SE, DIR_SW: r = OFF_NEG;
      default: r = OFF_ZERO;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/grid_jump_distance_table.sv
// Grid jump-distance table: cell bitmap, load path and eight-direction scan sequencer.
//
// The block holds one walkable bit per grid cell in a bitmap RAM with one write and one
// read port. A load beat (tuser = 0) writes one cell if it lies inside the grid. A query
// beat (tuser = 1) scans the eight directions from the given cell, one direction after
// the other, and returns one result beat. A query on the border of the grid skips the
// scan and returns zeros. An interior query runs, per direction, a setup state and then
// scan steps: each step reads three cells through the single bitmap read port, one read
// a cycle, and evaluates them in the EVAL state. A straight scan does one extra step
// first to read the side cells of the start cell and stops at the first blocked cell or
// jump point; a diagonal scan stops at the first step that would cut a corner or enter a
// blocked cell. The bitmap is not cleared at reset: every cell must be loaded before a
// query reads it. A finished result waits in the output register while loads are taken.
`timescale 1ns / 1ps
`default_nettype none
`include "grid_jump_distance_table_macros.svh"

module grid_jump_distance_table
  import gjdt_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst,
  // Input beats
  input  wire                     s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire  [IN_TDATA_W-1:0]   s_axis_tdata,   // cell_x[7:0], cell_y[15:8], walkable[16]
  input  wire                     s_axis_tuser,   // opcode[0]
  // Result beats
  output logic                    m_axis_tvalid,
  input  wire                     m_axis_tready,
  output logic [OUT_TDATA_W-1:0]  m_axis_tdata,   // dist_north[7:0], jump_north[8],
                                                  // dist_east[16:9], jump_east[17],
                                                  // dist_south[25:18], jump_south[26],
                                                  // dist_west[34:27], jump_west[35],
                                                  // dist_northeast[43:36],
                                                  // dist_southeast[51:44],
                                                  // dist_southwest[59:52],
                                                  // dist_northwest[67:60], zeros[71:68]
  // Configuration writes
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire                     cfg_index,
  input  wire  [DIM_W-1:0]        cfg_data
);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_RD0   = 3'd2;
  localparam logic [2:0] S_RD1   = 3'd3;
  localparam logic [2:0] S_RD2   = 3'd4;
  localparam logic [2:0] S_EVAL  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]       state;
  logic [DIR_W-1:0] dir;
  logic [DIM_W-1:0] grid_width;
  logic [DIM_W-1:0] grid_height;

  // Datapath registers
  coord_t           qx, qy;
  coord_t           px, py;
  dist_t            cnt;
  logic             init;
  logic             side_pos, side_neg;
  logic             b0, b1;
  logic             rd_inb;
  dist_t            dist_res [NUM_DIR];
  logic [3:0]       jump_res;
  logic [OUT_TDATA_W-1:0] out_data;

  // Input fields
  logic [X_W-1:0]   in_x;
  logic [Y_W-1:0]   in_y;
  logic             in_walk;
  logic             in_acc;

  assign in_x    = s_axis_tdata[X_W-1:0];
  assign in_y    = s_axis_tdata[X_W+Y_W-1:X_W];
  assign in_walk = s_axis_tdata[X_W+Y_W];
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tdata  = out_data;

  // Clamp the grid size to its legal range
  logic [DIM_W-1:0] w_eff, h_eff;
  always_comb begin
    if (grid_width < DIM_W'(MIN_DIM)) begin
      w_eff = DIM_W'(MIN_DIM);
    end else if (grid_width > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = grid_width;
    end
    if (grid_height < DIM_W'(MIN_DIM)) begin
      h_eff = DIM_W'(MIN_DIM);
    end else if (grid_height > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = grid_height;
    end
  end

  // Load and query checks against the grid in use
  logic load_in_grid, q_border;
  assign load_in_grid = ({1'b0, in_x} < w_eff) && ({1'b0, in_y} < h_eff);
  assign q_border = (in_x == '0) || (in_y == '0) ||
                    ({1'b0, in_x} >= w_eff - DIM_W'(1)) ||
                    ({1'b0, in_y} >= h_eff - DIM_W'(1));

  // Direction steps
  off_t   dx, dy;
  coord_t cdx, cdy;
  assign dx  = dir_dx(dir);
  assign dy  = dir_dy(dir);
  assign cdx = coord_t'(dx);
  assign cdy = coord_t'(dy);

  // Offset of the cell read in this cycle
  coord_t ox, oy, rx, ry;
  always_comb begin
    ox = '0;
    oy = '0;
    case (state)
      S_RD0: begin
        ox = dir[2] ? coord_t'(0) : cdx;
        oy = cdy;
      end
      S_RD1: begin
        ox = dir[2] ? cdx : cdx + cdy;
        oy = dir[2] ? coord_t'(0) : cdy + cdx;
      end
      S_RD2: begin
        ox = dir[2] ? cdx : cdx - cdy;
        oy = dir[2] ? cdy : cdy - cdx;
      end
      default: begin
        ox = '0;
        oy = '0;
      end
    endcase
    rx = px + ox;
    ry = py + oy;
  end

  // Cells outside the grid read as blocked
  logic rd_inb_now;
  assign rd_inb_now = !rx[COORD_W-1] && (rx[DIM_W-1:0] < w_eff) &&
                      !ry[COORD_W-1] && (ry[DIM_W-1:0] < h_eff);

  // Cell bitmap
  logic [0:0] rd_data;
  logic       map_we;
  assign map_we = in_acc && (s_axis_tuser == OP_LOAD) && load_in_grid;

  gjdt_ram #(
    .WIDTH (1),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr ({in_y, in_x}),
    .wdata (in_walk),
    .raddr ({ry[Y_W-1:0], rx[X_W-1:0]}),
    .rdata (rd_data)
  );

  logic rd_bit;
  assign rd_bit = rd_data[0] && rd_inb;

  // Evaluate one scan step from the three cells read
  dist_t      cnt_inc;
  step_eval_t ev;
  assign cnt_inc = (cnt == DIST_MAX) ? cnt : cnt + dist_t'(1);

  always_comb begin
    ev = '{stop: 1'b0, len: cnt, jump: 1'b0};
    if (dir[2]) begin
      // diagonal: both orthogonal neighbours and the diagonal cell open
      if (!(b0 && b1 && rd_bit)) begin
        ev.stop = 1'b1;
      end
    end else if (!init) begin
      if (!b0) begin
        ev.stop = 1'b1;
      end else if ((b1 && !side_pos) || (rd_bit && !side_neg)) begin
        ev = '{stop: 1'b1, len: cnt_inc, jump: 1'b1};
      end
    end
  end

  // Control: sequencer, output valid, configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      dir           <= DIR_N;
      m_axis_tvalid <= 1'b0;
      grid_width    <= DIM_W'(MAX_WIDTH);
      grid_height   <= DIM_W'(MAX_HEIGHT);
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRID_WIDTH:  grid_width  <= cfg_data;
          REG_GRID_HEIGHT: grid_height <= cfg_data;
          default: ;
        endcase
      end
      // raise the result once the output register is free, drop it once taken
      if ((state == S_DONE) && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc && (s_axis_tuser == OP_QUERY)) begin
            dir   <= DIR_N;
            state <= q_border ? S_DONE : S_START;
          end
        end
        S_START: state <= S_RD0;
        S_RD0:   state <= S_RD1;
        S_RD1:   state <= S_RD2;
        S_RD2:   state <= S_EVAL;
        S_EVAL: begin
          if (!ev.stop) begin
            state <= S_RD0;
          end else if (dir == DIR_NW) begin
            state <= S_DONE;
          end else begin
            dir   <= dir + DIR_W'(1);
            state <= S_START;
          end
        end
        S_DONE: begin
          // hold the result until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath: position, counters, captured cells, results
  always_ff @(posedge clk) begin
    rd_inb <= rd_inb_now;
    case (state)
      S_IDLE: begin
        if (in_acc && (s_axis_tuser == OP_QUERY)) begin
          qx <= coord_t'({2'b00, in_x});
          qy <= coord_t'({2'b00, in_y});
          for (int i = 0; i < NUM_DIR; i++) begin
            dist_res[i] <= '0;
          end
          jump_res <= '0;
        end
      end
      S_START: begin
        // straight scans start one cell back to pick up the side cells
        cnt  <= '0;
        init <= !dir[2];
        px   <= dir[2] ? qx : qx - cdx;
        py   <= dir[2] ? qy : qy - cdy;
      end
      S_RD1: b0 <= rd_bit;
      S_RD2: b1 <= rd_bit;
      S_EVAL: begin
        if (ev.stop) begin
          dist_res[dir] <= ev.len;
          if (!dir[2]) begin
            jump_res[dir[1:0]] <= ev.jump;
          end
        end else begin
          // advance one cell along the direction
          px <= px + cdx;
          py <= py + cdy;
          if (!init) begin
            cnt <= cnt_inc;
          end
          if (!dir[2]) begin
            side_pos <= b1;
            side_neg <= rd_bit;
          end
          init <= 1'b0;
        end
      end
      S_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_data <= {{OUT_PAD_W{1'b0}},
                       dist_res[DIR_NW], dist_res[DIR_SW],
                       dist_res[DIR_SE], dist_res[DIR_NE],
                       jump_res[DIR_W_[1:0]], dist_res[DIR_W_],
                       jump_res[DIR_S[1:0]],  dist_res[DIR_S],
                       jump_res[DIR_E[1:0]],  dist_res[DIR_E],
                       jump_res[DIR_N[1:0]],  dist_res[DIR_N]};
        end
      end
      default: ;
    endcase
  end

  // Checks
  `GJDT_ASSERT_IMP(a_pos_in_grid, state == S_EVAL,
    !px[COORD_W-1] && (px[DIM_W-1:0] < w_eff) && !py[COORD_W-1] && (py[DIM_W-1:0] < h_eff),
    "scan position left the grid")
  `GJDT_ASSERT_IMP(a_result_from_done, $rose(m_axis_tvalid), $past(state) == S_DONE,
    "result raised outside the final state")
  `GJDT_ASSERT_NXT(a_query_starts_scan, in_acc && (s_axis_tuser == OP_QUERY) && !q_border,
    (state == S_START) && (dir == DIR_N), "interior query did not start the north scan")
  `GJDT_ASSERT_NXT(a_load_stays_idle, in_acc && (s_axis_tuser == OP_LOAD), state == S_IDLE,
    "load left the idle state")

endmodule

`default_nettype wire

FILE: hdl/gjdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module gjdt_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
